// ===== sv/cnmf_pkg.sv =====
// ----------------------------------------------------------------------------
// Cross-neighbour minimum filter: shared package
// Character width, ranking constants, the issue-stage operation and the
// ranking functions used by the compare pipeline.
// ----------------------------------------------------------------------------
package cnmf_pkg;

  localparam int CHAR_W     = 7;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int ROWS_W     = 11;
  localparam int COLS_W     = 6;

  localparam logic [CHAR_W-1:0] START_CHAR  = 7'd123;
  localparam logic [CHAR_W-1:0] UPPER_A     = 7'd65;
  localparam logic [CHAR_W-1:0] UPPER_Z     = 7'd90;
  localparam logic [CHAR_W-1:0] CASE_OFFSET = 7'd32;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 1'b1;

  typedef struct packed {
    logic              valid;
    logic              use_single;
    logic              use_ch;
    logic              use_hi;
    logic              use_lo;
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              frame_end;
  } op_t;

  function automatic logic [CHAR_W-1:0] fold_key(input logic [CHAR_W-1:0] ch);
    fold_key = (ch >= UPPER_A && ch <= UPPER_Z) ? ch + CASE_OFFSET : ch;
  endfunction

  function automatic logic [CHAR_W-1:0] pick(input logic [CHAR_W-1:0] best,
                                             input logic [CHAR_W-1:0] cand);
    logic [2*CHAR_W-1:0] kb;
    logic [2*CHAR_W-1:0] kc;
    kb = {fold_key(best), best};
    kc = {fold_key(cand), cand};
    pick = (kc < kb) ? cand : best;
  endfunction

endpackage

// ===== sv/cnmf_line_store.sv =====
// ----------------------------------------------------------------------------
// Cross-neighbour minimum filter: line store
// One row of characters with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module cnmf_line_store #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [cnmf_pkg::CHAR_W-1:0] wr_data,
  input  logic [AW-1:0]               rd_addr0,
  input  logic [AW-1:0]               rd_addr1,
  output logic [cnmf_pkg::CHAR_W-1:0] rd_data0,
  output logic [cnmf_pkg::CHAR_W-1:0] rd_data1
);

  logic [cnmf_pkg::CHAR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd_data0 <= mem[rd_addr0];
      rd_data1 <= mem[rd_addr1];
    end
  end

endmodule

// ===== sv/cnmf_min_pipe.sv =====
// ----------------------------------------------------------------------------
// Cross-neighbour minimum filter: compare pipeline
// Two register stages: pairwise minima, then the final minimum in the
// output register.
// ----------------------------------------------------------------------------
module cnmf_min_pipe (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  cnmf_pkg::op_t               op,
  input  logic [cnmf_pkg::CHAR_W-1:0] single_data,
  input  logic [cnmf_pkg::CHAR_W-1:0] hi_data,
  input  logic [cnmf_pkg::CHAR_W-1:0] lo_data,
  output logic                        out_valid,
  output logic [cnmf_pkg::CHAR_W-1:0] min_char,
  output logic                        last_of_run,
  output logic                        frame_end
);

  logic [cnmf_pkg::CHAR_W-1:0] cand_single;
  logic [cnmf_pkg::CHAR_W-1:0] cand_ch;
  logic [cnmf_pkg::CHAR_W-1:0] cand_hi;
  logic [cnmf_pkg::CHAR_W-1:0] cand_lo;
  logic                        s2_valid;
  logic [cnmf_pkg::CHAR_W-1:0] s2_pair0;
  logic [cnmf_pkg::CHAR_W-1:0] s2_pair1;
  logic                        s2_last;
  logic                        s2_frame_end;

  assign cand_single = op.use_single ? single_data : cnmf_pkg::START_CHAR;
  assign cand_ch     = op.use_ch     ? op.ch       : cnmf_pkg::START_CHAR;
  assign cand_hi     = op.use_hi     ? hi_data     : cnmf_pkg::START_CHAR;
  assign cand_lo     = op.use_lo     ? lo_data     : cnmf_pkg::START_CHAR;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s2_valid  <= op.valid;
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_pair0     <= cnmf_pkg::pick(cand_single, cand_ch);
      s2_pair1     <= cnmf_pkg::pick(cand_hi, cand_lo);
      s2_last      <= op.last;
      s2_frame_end <= op.frame_end;
      min_char     <= cnmf_pkg::pick(s2_pair0, s2_pair1);
      last_of_run  <= s2_last;
      frame_end    <= s2_frame_end;
    end
  end

endmodule

// ===== sv/cross_neighbour_min_filter_core.sv =====
// ----------------------------------------------------------------------------
// Cross-neighbour minimum filter core
// Characters of a matrix enter on the in channel in raster order, one
// transfer per cycle when not stalled. For each cell the out channel gives the
// smallest of its four neighbours, ranked case-folded with upper case winning
// ties, or '{' when none ranks lower. Results for row r-1 leave as row r
// enters; the last character of a frame also flushes the final row, during
// which the in channel is stalled and one flush result per column is issued
// per cycle unless the out channel stalls. Each result passes through the
// issue, pairwise and output registers; the sustained rate is one cell per
// cycle when nothing stalls, set by the issue stage that reads both line
// stores when enabled. A stall on the out channel freezes the whole pipeline
// and stalls the in channel in the same cycle. Configuration writes restart
// the frame at the first cell; the user must make them only while the block
// is idle, which it does not enforce. Reset sets both sizes to one, clears
// positions and empties the pipeline; line stores are not cleared.
// ----------------------------------------------------------------------------
module cross_neighbour_min_filter_core #(
  parameter int MAX_COLS = 32,
  parameter int MAX_ROWS = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [cnmf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cnmf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [cnmf_pkg::CHAR_W-1:0]     in_char,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [cnmf_pkg::CHAR_W-1:0]     min_char,
  output logic                            last_of_run,
  output logic                            frame_end
);

  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [RW-1:0] rows_last;
  logic [CW-1:0] cols_last;
  logic [RW-1:0] row_pos;
  logic [CW-1:0] col_pos;
  logic          flushing;
  logic [CW-1:0] flush_col;
  logic          flush_odd;
  logic          flush_has_prev;

  logic          en;
  logic          accept;
  logic          last_col;
  logic          last_row;
  logic          last_cell;

  logic [cnmf_pkg::ROWS_W-1:0] cfg_rows;
  logic [cnmf_pkg::COLS_W-1:0] cfg_cols;

  cnmf_pkg::op_t op_next;
  cnmf_pkg::op_t op;
  logic          pair_sel_next;
  logic          pair_sel;
  logic [CW-1:0] base_addr;
  logic [CW-1:0] hi_addr;
  logic [CW-1:0] lo_addr;

  logic [cnmf_pkg::CHAR_W-1:0] even_d0;
  logic [cnmf_pkg::CHAR_W-1:0] even_d1;
  logic [cnmf_pkg::CHAR_W-1:0] odd_d0;
  logic [cnmf_pkg::CHAR_W-1:0] odd_d1;
  logic [cnmf_pkg::CHAR_W-1:0] single_data;
  logic [cnmf_pkg::CHAR_W-1:0] hi_data;
  logic [cnmf_pkg::CHAR_W-1:0] lo_data;

  assign en        = !(out_valid && out_stall);
  assign in_stall  = flushing || !en;
  assign accept    = in_valid && !in_stall;
  assign last_col  = (col_pos == cols_last);
  assign last_row  = (row_pos == rows_last);
  assign last_cell = last_col && last_row;

  assign cfg_rows = cfg_data[cnmf_pkg::ROWS_W-1:0];
  assign cfg_cols = cfg_data[cnmf_pkg::COLS_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_last      <= '0;
      cols_last      <= '0;
      row_pos        <= '0;
      col_pos        <= '0;
      flushing       <= 1'b0;
      flush_col      <= '0;
      flush_odd      <= 1'b0;
      flush_has_prev <= 1'b0;
      op             <= '0;
      pair_sel       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          cnmf_pkg::REG_ROWS_IN_USE: begin
            if (cfg_rows == '0) begin
              rows_last <= '0;
            end else if (32'(cfg_rows) > MAX_ROWS) begin
              rows_last <= RW'(MAX_ROWS - 1);
            end else begin
              rows_last <= RW'(cfg_rows - 1'b1);
            end
          end
          cnmf_pkg::REG_COLS_IN_USE: begin
            if (cfg_cols == '0) begin
              cols_last <= '0;
            end else if (32'(cfg_cols) > MAX_COLS) begin
              cols_last <= CW'(MAX_COLS - 1);
            end else begin
              cols_last <= CW'(cfg_cols - 1'b1);
            end
          end
          default: begin
          end
        endcase
        row_pos <= '0;
        col_pos <= '0;
      end else if (accept) begin
        if (last_cell) begin
          row_pos        <= '0;
          col_pos        <= '0;
          flushing       <= 1'b1;
          flush_col      <= '0;
          flush_odd      <= row_pos[0];
          flush_has_prev <= (row_pos != '0);
        end else if (last_col) begin
          row_pos <= row_pos + RW'(1);
          col_pos <= '0;
        end else begin
          col_pos <= col_pos + CW'(1);
        end
      end else if (flushing && en) begin
        flush_col <= flush_col + CW'(1);
        if (flush_col == cols_last) begin
          flushing <= 1'b0;
        end
      end
      if (en) begin
        op       <= op_next;
        pair_sel <= pair_sel_next;
      end
    end
  end

  // The pair store, which holds the row being reported, supplies right and left
  // neighbours, the single store the one above; their roles swap row by row.
  always_comb begin
    op_next       = '0;
    pair_sel_next = 1'b0;
    base_addr     = col_pos;
    if (flushing) begin
      base_addr          = flush_col;
      op_next.valid      = 1'b1;
      op_next.use_single = flush_has_prev;
      op_next.use_hi     = (flush_col != cols_last);
      op_next.use_lo     = (flush_col != '0);
      op_next.last       = (flush_col == cols_last);
      op_next.frame_end  = (flush_col == cols_last);
      pair_sel_next      = flush_odd;
    end else if (accept && row_pos != '0) begin
      op_next.valid      = 1'b1;
      op_next.use_single = (row_pos != RW'(1));
      op_next.use_ch     = 1'b1;
      op_next.ch         = in_char;
      op_next.use_hi     = !last_col;
      op_next.use_lo     = (col_pos != '0);
      op_next.last       = !last_cell;
      pair_sel_next      = ~row_pos[0];
    end
  end

  assign hi_addr = base_addr + CW'(1);
  assign lo_addr = base_addr - CW'(1);

  cnmf_line_store #(
    .DEPTH (MAX_COLS),
    .AW    (CW)
  ) u_middle_store (
    .clk      (clk),
    .en       (en),
    .wr_en    (accept && !row_pos[0]),
    .wr_addr  (col_pos),
    .wr_data  (in_char),
    .rd_addr0 (pair_sel_next ? base_addr : hi_addr),
    .rd_addr1 (lo_addr),
    .rd_data0 (even_d0),
    .rd_data1 (even_d1)
  );

  cnmf_line_store #(
    .DEPTH (MAX_COLS),
    .AW    (CW)
  ) u_outer_store (
    .clk      (clk),
    .en       (en),
    .wr_en    (accept && row_pos[0]),
    .wr_addr  (col_pos),
    .wr_data  (in_char),
    .rd_addr0 (pair_sel_next ? hi_addr : base_addr),
    .rd_addr1 (lo_addr),
    .rd_data0 (odd_d0),
    .rd_data1 (odd_d1)
  );

  assign single_data = pair_sel ? even_d0 : odd_d0;
  assign hi_data     = pair_sel ? odd_d0  : even_d0;
  assign lo_data     = pair_sel ? odd_d1  : even_d1;

  cnmf_min_pipe u_min_pipe (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .op          (op),
    .single_data (single_data),
    .hi_data     (hi_data),
    .lo_data     (lo_data),
    .out_valid   (out_valid),
    .min_char    (min_char),
    .last_of_run (last_of_run),
    .frame_end   (frame_end)
  );

endmodule

// ===== sv/cnmf_checker.sv =====
// ----------------------------------------------------------------------------
// Cross-neighbour minimum filter: port checker
// Assertions on the top level's ports, attached by a bind statement.
// ----------------------------------------------------------------------------
module cnmf_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [cnmf_pkg::CHAR_W-1:0] min_char,
  input logic                        last_of_run,
  input logic                        frame_end
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(min_char) &&
      $stable(last_of_run) && $stable(frame_end))
    else $error("stalled result changed");

  a_stall_back: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while the output is stalled");

  a_min_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> min_char <= cnmf_pkg::START_CHAR)
    else $error("result ranks above the start value");

  a_frame_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> last_of_run)
    else $error("frame end not on the last result of its transfer");

  a_known: assert property (@(posedge clk) disable iff (rst)
    !$isunknown({in_valid, in_stall, out_valid}))
    else $error("handshake signal unknown");

endmodule

bind cross_neighbour_min_filter_core cnmf_checker u_cnmf_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .min_char    (min_char),
  .last_of_run (last_of_run),
  .frame_end   (frame_end)
);
